>>> sv/jpw_pkg.sv
// Package for the jitter point walker: payload and state types, register
// codes, controller/datapath command types and the saturation helper.
// No dependencies.
package jpw_pkg;

    // Default number of animated points
    localparam int unsigned NUM_POINTS_DEF = 64;

    // Field widths
    localparam int unsigned NODE_W    = 6;
    localparam int unsigned NODE_SPAN = 2 ** NODE_W;
    localparam int unsigned COORD_W   = 32;
    localparam int unsigned MUL_W     = 33;
    localparam int unsigned PROD_W    = 2 * MUL_W;
    localparam int unsigned SAT_IN_W  = 50;

    // APB register map
    localparam int unsigned ADDR_W    = 4;
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_RADIUS   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FRICTION = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_STEP     = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_SPAN     = 2'd3;

    // Register reset values
    localparam logic [30:0] RADIUS_RST   = 31'd1310720;
    localparam logic [15:0] FRICTION_RST = 16'd62259;
    localparam logic [30:0] STEP_RST     = 31'd65536;
    localparam logic [4:0]  SPAN_RST     = 5'd8;

    // Kick direction codes
    localparam logic [1:0] DIR_POS_X = 2'd0;
    localparam logic [1:0] DIR_NEG_X = 2'd1;
    localparam logic [1:0] DIR_POS_Y = 2'd2;
    localparam logic [1:0] DIR_NEG_Y = 2'd3;

    // Q16.16 one
    localparam logic signed [MUL_W-1:0] Q_ONE = 33'sd65536;

    typedef struct packed {
        logic [NODE_W-1:0]         node;
        logic signed [COORD_W-1:0] base_x;
        logic signed [COORD_W-1:0] base_y;
        logic signed [COORD_W-1:0] mouse_x;
        logic signed [COORD_W-1:0] mouse_y;
        logic [1:0]                direction;
    } t_in_item;

    typedef struct packed {
        logic [NODE_W-1:0]         node_out;
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic                      moved;
    } t_out_item;

    typedef struct packed {
        logic [30:0] select_radius;
        logic [15:0] friction;
        logic [30:0] step_size;
        logic [4:0]  span_shift;
    } t_cfg;

    // One point's stored state
    typedef struct packed {
        logic signed [COORD_W-1:0] off_x;
        logic signed [COORD_W-1:0] off_y;
        logic signed [COORD_W-1:0] spd_x;
        logic signed [COORD_W-1:0] spd_y;
    } t_point;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_POS,
        ST_DIFF,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_R,
        ST_CMP,
        ST_DAMP_X,
        ST_VEL_X,
        ST_FIN_X,
        ST_DAMP_Y,
        ST_VEL_Y,
        ST_FIN_Y,
        ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLEAR,
        DP_LOAD,
        DP_POS,
        DP_DIFF,
        DP_SQ_X,
        DP_SQ_Y,
        DP_SQ_R,
        DP_CMP,
        DP_DAMP_X,
        DP_VEL_X,
        DP_FIN_X,
        DP_DAMP_Y,
        DP_VEL_Y,
        DP_FIN_Y
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   mem_we;
        logic   out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic moved;
        logic clr_last;
    } t_dp_status;

    // Clamp to the signed 32-bit range
    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SAT_IN_W-1:0] v);
        logic signed [SAT_IN_W-1:0] hi;
        logic signed [SAT_IN_W-1:0] lo;
        hi = SAT_IN_W'(33'sh0_7FFF_FFFF);
        lo = SAT_IN_W'(33'sh1_8000_0000);
        if (v > hi) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = v[COORD_W-1:0];
        end
    endfunction

endpackage

>>> sv/jpw_regs.sv
// Configuration register file of the jitter point walker, APB-style port.
// Depends on jpw_pkg.
module jpw_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [jpw_pkg::ADDR_W-1:0]   paddr,
    input  logic [jpw_pkg::DATA_W-1:0]   pwdata,
    output logic [jpw_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output jpw_pkg::t_cfg                o_cfg
);

    jpw_pkg::t_cfg                     r_cfg;
    logic [jpw_pkg::REG_IDX_W-1:0]     w_idx;
    logic                              w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[jpw_pkg::ADDR_W-1:2];
    assign w_wr   = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.select_radius <= jpw_pkg::RADIUS_RST;
            r_cfg.friction      <= jpw_pkg::FRICTION_RST;
            r_cfg.step_size     <= jpw_pkg::STEP_RST;
            r_cfg.span_shift    <= jpw_pkg::SPAN_RST;
        end else if (w_wr) begin
            case (w_idx)
                jpw_pkg::REG_RADIUS:   r_cfg.select_radius <= pwdata[30:0];
                jpw_pkg::REG_FRICTION: r_cfg.friction      <= pwdata[15:0];
                jpw_pkg::REG_STEP:     r_cfg.step_size     <= pwdata[30:0];
                jpw_pkg::REG_SPAN:     r_cfg.span_shift    <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (w_idx)
            jpw_pkg::REG_RADIUS:   prdata = jpw_pkg::DATA_W'(r_cfg.select_radius);
            jpw_pkg::REG_FRICTION: prdata = jpw_pkg::DATA_W'(r_cfg.friction);
            jpw_pkg::REG_STEP:     prdata = jpw_pkg::DATA_W'(r_cfg.step_size);
            jpw_pkg::REG_SPAN:     prdata = jpw_pkg::DATA_W'(r_cfg.span_shift);
            default:               prdata = '0;
        endcase
    end

endmodule

>>> sv/jpw_ctrl.sv
// Controller of the jitter point walker: sequences the datapath through the
// clear pass, position, distance test and walk step; owns both handshakes.
// Depends on jpw_pkg.
module jpw_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output jpw_pkg::t_dp_cmd      o_cmd,
    input  jpw_pkg::t_dp_status   i_status
);

    jpw_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == jpw_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;

    // State and output-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= jpw_pkg::ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state        = r_state;
        o_cmd.op       = jpw_pkg::DP_NOP;
        o_cmd.mem_we   = 1'b0;
        o_cmd.out_load = 1'b0;
        n_out_valid    = r_out_valid & ~i_out_ready;
        case (r_state)
            jpw_pkg::ST_CLEAR: begin
                o_cmd.op     = jpw_pkg::DP_CLEAR;
                o_cmd.mem_we = 1'b1;
                if (i_status.clr_last) begin
                    n_state = jpw_pkg::ST_IDLE;
                end
            end
            jpw_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = jpw_pkg::DP_LOAD;
                    n_state  = jpw_pkg::ST_POS;
                end
            end
            jpw_pkg::ST_POS: begin
                o_cmd.op = jpw_pkg::DP_POS;
                n_state  = jpw_pkg::ST_DIFF;
            end
            jpw_pkg::ST_DIFF: begin
                o_cmd.op = jpw_pkg::DP_DIFF;
                n_state  = jpw_pkg::ST_SQ_X;
            end
            jpw_pkg::ST_SQ_X: begin
                o_cmd.op = jpw_pkg::DP_SQ_X;
                n_state  = jpw_pkg::ST_SQ_Y;
            end
            jpw_pkg::ST_SQ_Y: begin
                o_cmd.op = jpw_pkg::DP_SQ_Y;
                n_state  = jpw_pkg::ST_SQ_R;
            end
            jpw_pkg::ST_SQ_R: begin
                o_cmd.op = jpw_pkg::DP_SQ_R;
                n_state  = jpw_pkg::ST_CMP;
            end
            jpw_pkg::ST_CMP: begin
                o_cmd.op = jpw_pkg::DP_CMP;
                n_state  = i_status.moved ? jpw_pkg::ST_DAMP_X : jpw_pkg::ST_DONE;
            end
            jpw_pkg::ST_DAMP_X: begin
                o_cmd.op = jpw_pkg::DP_DAMP_X;
                n_state  = jpw_pkg::ST_VEL_X;
            end
            jpw_pkg::ST_VEL_X: begin
                o_cmd.op = jpw_pkg::DP_VEL_X;
                n_state  = jpw_pkg::ST_FIN_X;
            end
            jpw_pkg::ST_FIN_X: begin
                o_cmd.op = jpw_pkg::DP_FIN_X;
                n_state  = jpw_pkg::ST_DAMP_Y;
            end
            jpw_pkg::ST_DAMP_Y: begin
                o_cmd.op = jpw_pkg::DP_DAMP_Y;
                n_state  = jpw_pkg::ST_VEL_Y;
            end
            jpw_pkg::ST_VEL_Y: begin
                o_cmd.op = jpw_pkg::DP_VEL_Y;
                n_state  = jpw_pkg::ST_FIN_Y;
            end
            jpw_pkg::ST_FIN_Y: begin
                o_cmd.op = jpw_pkg::DP_FIN_Y;
                n_state  = jpw_pkg::ST_DONE;
            end
            jpw_pkg::ST_DONE: begin
                // Write back and hand over once the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.mem_we   = 1'b1;
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = jpw_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = jpw_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/jpw_dp.sv
// Datapath of the jitter point walker: point state memory, shared 33x33
// multiplier, saturating adders and the output register.
// Depends on jpw_pkg.
module jpw_dp #(
    parameter int unsigned NUM_POINTS = jpw_pkg::NUM_POINTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  jpw_pkg::t_cfg         i_cfg,
    input  jpw_pkg::t_in_item     i_in_data,
    output jpw_pkg::t_out_item    o_out_data,
    input  jpw_pkg::t_dp_cmd      i_cmd,
    output jpw_pkg::t_dp_status   o_status
);

    localparam int unsigned IDX_W = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
    localparam int unsigned MW    = jpw_pkg::MUL_W;
    localparam int unsigned PW    = jpw_pkg::PROD_W;
    localparam int unsigned SW    = jpw_pkg::SAT_IN_W;

    // Point state memory
    jpw_pkg::t_point r_mem [NUM_POINTS];
    jpw_pkg::t_point r_rd;

    // Item and working registers
    jpw_pkg::t_in_item  r_item;
    jpw_pkg::t_out_item r_out;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   r_clr;
    logic signed [31:0] r_off_x, r_off_y, r_spd_x, r_spd_y;
    logic signed [31:0] r_px, r_py;
    logic signed [31:0] r_up_x, r_up_y;
    logic [31:0]        r_dx, r_dy;
    logic [63:0]        r_sx, r_sy;
    logic signed [PW-1:0] r_prod;
    logic               r_moved;

    logic [IDX_W-1:0]   w_mod_tab [jpw_pkg::NODE_SPAN];
    logic [IDX_W-1:0]   w_waddr;
    jpw_pkg::t_point    w_wdata;
    logic signed [32:0] w_sum_x, w_sum_y, w_dif_x, w_dif_y;
    logic [64:0]        w_sum;
    logic               w_moved;
    logic signed [MW-1:0] w_ma, w_mb, w_up_e, w_mag, w_t, w_step;
    logic signed [PW-1:0] w_mul;
    logic signed [31:0] w_up_sel, w_off_sel, w_spd_sel;
    logic signed [31:0] w_s, w_s2, w_off_new;
    logic signed [31:0] w_kick_p_x, w_kick_n_x, w_kick_p_y, w_kick_n_y;

    // Node index folded onto the point count
    for (genvar gi = 0; gi < jpw_pkg::NODE_SPAN; gi++) begin : g_mod
        assign w_mod_tab[gi] = IDX_W'(gi % NUM_POINTS);
    end

    // Memory write: zero during the clear pass, working state on completion
    assign w_waddr = (i_cmd.op == jpw_pkg::DP_CLEAR) ? r_clr : r_idx;
    always_comb begin
        if (i_cmd.op == jpw_pkg::DP_CLEAR) begin
            w_wdata = '0;
        end else begin
            w_wdata.off_x = r_off_x;
            w_wdata.off_y = r_off_y;
            w_wdata.spd_x = r_spd_x;
            w_wdata.spd_y = r_spd_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.op == jpw_pkg::DP_LOAD) begin
            r_rd <= r_mem[w_mod_tab[i_in_data.node]];
        end
    end

    // Clear pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.op == jpw_pkg::DP_CLEAR) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    assign o_status.clr_last = (r_clr == IDX_W'(NUM_POINTS - 1));

    // Displayed position and distance to the mouse
    assign w_sum_x = 33'(r_item.base_x) + 33'(r_rd.off_x);
    assign w_sum_y = 33'(r_item.base_y) + 33'(r_rd.off_y);
    assign w_dif_x = 33'(r_item.mouse_x) - 33'(r_px);
    assign w_dif_y = 33'(r_item.mouse_y) - 33'(r_py);

    // Squared distance against squared radius
    assign w_sum   = 65'(r_sx) + 65'(r_sy);
    assign w_moved = (w_sum > 65'(r_prod[63:0]));
    assign o_status.moved = w_moved;

    // Per-axis selection for the walk step
    always_comb begin
        case (i_cmd.op)
            jpw_pkg::DP_DAMP_Y, jpw_pkg::DP_VEL_Y, jpw_pkg::DP_FIN_Y: begin
                w_up_sel  = r_up_y;
                w_off_sel = r_off_y;
                w_spd_sel = r_spd_y;
            end
            default: begin
                w_up_sel  = r_up_x;
                w_off_sel = r_off_x;
                w_spd_sel = r_spd_x;
            end
        endcase
    end

    // Damping factor operand: one minus |offset/span|
    assign w_up_e = MW'(w_up_sel);
    assign w_mag  = w_up_e[MW-1] ? -w_up_e : w_up_e;
    assign w_t    = jpw_pkg::Q_ONE - w_mag;

    // Random kick
    assign w_step     = $signed({2'b00, i_cfg.step_size});
    assign w_kick_p_x = jpw_pkg::sat32(SW'(MW'(r_spd_x) + w_step));
    assign w_kick_n_x = jpw_pkg::sat32(SW'(MW'(r_spd_x) - w_step));
    assign w_kick_p_y = jpw_pkg::sat32(SW'(MW'(r_spd_y) + w_step));
    assign w_kick_n_y = jpw_pkg::sat32(SW'(MW'(r_spd_y) - w_step));

    // Shared multiplier operands
    always_comb begin
        case (i_cmd.op)
            jpw_pkg::DP_SQ_X: begin
                w_ma = $signed({1'b0, r_dx});
                w_mb = $signed({1'b0, r_dx});
            end
            jpw_pkg::DP_SQ_Y: begin
                w_ma = $signed({1'b0, r_dy});
                w_mb = $signed({1'b0, r_dy});
            end
            jpw_pkg::DP_SQ_R: begin
                w_ma = $signed({2'b00, i_cfg.select_radius});
                w_mb = $signed({2'b00, i_cfg.select_radius});
            end
            jpw_pkg::DP_DAMP_X, jpw_pkg::DP_DAMP_Y: begin
                w_ma = $signed({17'd0, i_cfg.friction});
                w_mb = w_t;
            end
            default: begin
                // speed times damping factor (product register holds the factor)
                w_ma = MW'(w_spd_sel);
                w_mb = $signed(r_prod[48:16]);
            end
        endcase
    end

    assign w_mul = PW'(w_ma) * PW'(w_mb);

    // Speed and offset update from the registered product
    assign w_s       = jpw_pkg::sat32($signed(r_prod[PW-1:16]));
    assign w_s2      = jpw_pkg::sat32(SW'(MW'(w_s) - MW'(w_up_sel)));
    assign w_off_new = jpw_pkg::sat32(SW'(MW'(w_off_sel) + MW'(w_s2)));

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            jpw_pkg::DP_LOAD: begin
                r_item <= i_in_data;
                r_idx  <= w_mod_tab[i_in_data.node];
            end
            jpw_pkg::DP_POS: begin
                r_px    <= jpw_pkg::sat32(SW'(w_sum_x));
                r_py    <= jpw_pkg::sat32(SW'(w_sum_y));
                r_off_x <= r_rd.off_x;
                r_off_y <= r_rd.off_y;
                r_spd_x <= r_rd.spd_x;
                r_spd_y <= r_rd.spd_y;
            end
            jpw_pkg::DP_DIFF: begin
                r_dx <= w_dif_x[32] ? 32'(-w_dif_x) : w_dif_x[31:0];
                r_dy <= w_dif_y[32] ? 32'(-w_dif_y) : w_dif_y[31:0];
            end
            jpw_pkg::DP_SQ_X: begin
                r_prod <= w_mul;
            end
            jpw_pkg::DP_SQ_Y: begin
                r_sx   <= r_prod[63:0];
                r_prod <= w_mul;
            end
            jpw_pkg::DP_SQ_R: begin
                r_sy   <= r_prod[63:0];
                r_prod <= w_mul;
            end
            jpw_pkg::DP_CMP: begin
                r_moved <= w_moved;
                r_up_x  <= r_off_x >>> i_cfg.span_shift;
                r_up_y  <= r_off_y >>> i_cfg.span_shift;
            end
            jpw_pkg::DP_DAMP_X: begin
                r_prod <= w_mul;
                case (r_item.direction)
                    jpw_pkg::DIR_POS_X: r_spd_x <= w_kick_p_x;
                    jpw_pkg::DIR_NEG_X: r_spd_x <= w_kick_n_x;
                    jpw_pkg::DIR_POS_Y: r_spd_y <= w_kick_p_y;
                    jpw_pkg::DIR_NEG_Y: r_spd_y <= w_kick_n_y;
                    default: ;
                endcase
            end
            jpw_pkg::DP_VEL_X, jpw_pkg::DP_DAMP_Y, jpw_pkg::DP_VEL_Y: begin
                r_prod <= w_mul;
            end
            jpw_pkg::DP_FIN_X: begin
                r_spd_x <= w_s2;
                r_off_x <= w_off_new;
            end
            jpw_pkg::DP_FIN_Y: begin
                r_spd_y <= w_s2;
                r_off_y <= w_off_new;
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.node_out <= r_item.node;
            r_out.out_x    <= r_px;
            r_out.out_y    <= r_py;
            r_out.moved    <= r_moved;
        end
    end

    assign o_out_data = r_out;

endmodule

>>> sv/jitter_point_walker.sv
// Top level of the jitter point walker: register file, controller and datapath.
// Depends on jpw_pkg, jpw_regs, jpw_ctrl and jpw_dp.
//
// Each input transaction updates one animated point and returns one result
// transaction with the displayed position (base plus the offset held before
// this update) and a flag telling whether the point took a random-walk step.
// After reset the block runs a clearing pass over the point memory, one entry
// a cycle; no input is accepted until it finishes, while register writes are
// taken at any time. Items are handled one at a time: a point inside the
// select radius goes from the distance test straight to write-back, while a
// point that steps also runs the damping and speed states for each axis. The
// single shared 33x33 multiplier does the two distance squares and the
// squared radius, then the damping factor and the damped speed for each
// axis. The finished result sits in an output register; a new item may be
// accepted while it waits, and the block holds only at the end of that next
// item if the previous result is still not taken.
module jitter_point_walker #(
    parameter int unsigned NUM_POINTS = jpw_pkg::NUM_POINTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  jpw_pkg::t_in_item            i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output jpw_pkg::t_out_item           o_out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [jpw_pkg::ADDR_W-1:0]   paddr,
    input  logic [jpw_pkg::DATA_W-1:0]   pwdata,
    output logic [jpw_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    jpw_pkg::t_cfg       w_cfg;
    jpw_pkg::t_dp_cmd    w_cmd;
    jpw_pkg::t_dp_status w_status;

    // Configuration registers
    jpw_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Sequencer
    jpw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    // Arithmetic and point memory
    jpw_dp #(
        .NUM_POINTS (NUM_POINTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data),
        .i_cmd      (w_cmd),
        .o_status   (w_status)
    );

endmodule

>>> dv/jitter_point_walker_tb.sv
// Self-checking testbench for jitter_point_walker: directed vectors, then random phases
// under several register settings and idle patterns, checked against a local predictor.
// Depends on jpw_pkg and the jitter_point_walker RTL.
module jitter_point_walker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_PTS        = jpw_pkg::NUM_POINTS_DEF;
    localparam int PHASES         = 8;
    localparam int ITEMS_PER_PHASE = 190;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 20;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS    = 200;
    localparam int P_MAX          = 32'sh7FFF_FFFF;
    localparam int P_MIN          = 32'sh8000_0000;
    localparam longint MAX32      = 64'sd2147483647;
    localparam longint MIN32      = -64'sd2147483648;

    // One directed vector; want is used only where fixed is set
    typedef struct {
        jpw_pkg::t_in_item  stim;
        bit                 fixed;
        jpw_pkg::t_out_item want;
    } t_vector;

    // DUT connections
    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               in_valid  = 1'b0;
    jpw_pkg::t_in_item  in_data   = '0;
    logic               out_ready = 1'b0;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [jpw_pkg::ADDR_W-1:0] paddr  = '0;
    logic [jpw_pkg::DATA_W-1:0] pwdata = '0;
    logic                       o_in_ready;
    logic                       o_out_valid;
    jpw_pkg::t_out_item         o_out_data;
    logic [jpw_pkg::DATA_W-1:0] prdata;
    logic                       pready;

    // Predictor copy of registers and point memory
    longint radius_q;
    longint friction_q;
    longint step_q;
    longint span_q;
    int     off_x [NUM_PTS];
    int     off_y [NUM_PTS];
    int     spd_x [NUM_PTS];
    int     spd_y [NUM_PTS];

    jpw_pkg::t_out_item awaited_positions[$];
    t_vector   vectors[$];
    int        mismatches   = 0;
    int        send_idle_pct = 0;
    int        stall_pct    = 0;
    int        hold_asked   = 0;
    int        hold_served  = 0;
    int        hold_left    = 0;
    int        quiet_cycles = 0;

    jitter_point_walker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic int clamp32(input longint v);
        if (v > MAX32) begin
            return P_MAX;
        end
        if (v < MIN32) begin
            return P_MIN;
        end
        return int'(v);
    endfunction

    // One axis of a walk step; returns {new offset, new speed}
    function automatic logic [63:0] drift_axis(input int pos, input int vel);
        longint up;
        longint mag;
        longint damp;
        int     s;
        up   = longint'(pos) >>> span_q;
        mag  = (up < 0) ? -up : up;
        damp = (friction_q * (64'sd65536 - mag)) >>> 16;
        s    = clamp32((longint'(vel) * damp) >>> 16);
        s    = clamp32(longint'(s) - up);
        return {clamp32(longint'(pos) + longint'(s)), s};
    endfunction

    // Expected result of one transaction; updates the point memory
    function automatic jpw_pkg::t_out_item advance_point(input jpw_pkg::t_in_item it);
        jpw_pkg::t_out_item res;
        int          k;
        int          px;
        int          py;
        longint      dx;
        longint      dy;
        logic [63:0] ux;
        logic [63:0] uy;
        logic [64:0] dist2;
        logic [64:0] r2;
        bit          far;
        k     = int'(it.node) % NUM_PTS;
        px    = clamp32(longint'($signed(it.base_x)) + longint'(off_x[k]));
        py    = clamp32(longint'($signed(it.base_y)) + longint'(off_y[k]));
        dx    = longint'($signed(it.mouse_x)) - longint'(px);
        dy    = longint'($signed(it.mouse_y)) - longint'(py);
        ux    = (dx < 0) ? -dx : dx;
        uy    = (dy < 0) ? -dy : dy;
        dist2 = 65'(ux) * 65'(ux) + 65'(uy) * 65'(uy);
        r2    = 65'(radius_q * radius_q);
        far   = dist2 > r2;
        if (far) begin
            case (it.direction)
                jpw_pkg::DIR_POS_X: spd_x[k] = clamp32(longint'(spd_x[k]) + step_q);
                jpw_pkg::DIR_NEG_X: spd_x[k] = clamp32(longint'(spd_x[k]) - step_q);
                jpw_pkg::DIR_POS_Y: spd_y[k] = clamp32(longint'(spd_y[k]) + step_q);
                default:            spd_y[k] = clamp32(longint'(spd_y[k]) - step_q);
            endcase
            {off_x[k], spd_x[k]} = drift_axis(off_x[k], spd_x[k]);
            {off_y[k], spd_y[k]} = drift_axis(off_y[k], spd_y[k]);
        end
        res.node_out = it.node;
        res.out_x    = px;
        res.out_y    = py;
        res.moved    = far;
        return res;
    endfunction

    function automatic void add_vector(input int n, input int bx, input int by,
                                       input int mx, input int my, input logic [1:0] dir,
                                       input int fixed, input int wx, input int wy,
                                       input int wm);
        t_vector v;
        v.stim.node      = jpw_pkg::NODE_W'(n);
        v.stim.base_x    = bx;
        v.stim.base_y    = by;
        v.stim.mouse_x   = mx;
        v.stim.mouse_y   = my;
        v.stim.direction = dir;
        v.fixed          = (fixed != 0);
        v.want.node_out  = jpw_pkg::NODE_W'(n);
        v.want.out_x     = wx;
        v.want.out_y     = wy;
        v.want.moved     = (wm != 0);
        vectors.push_back(v);
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(5))
            0:       return P_MAX;
            1:       return P_MIN;
            2:       return int'($urandom_range(2097152)) - 1048576;
            3:       return int'($urandom) >>> $urandom_range(31);
            default: return int'($urandom);
        endcase
    endfunction

    // Random transaction: hot nodes so state builds up, mouse far, on the radius or inside
    function automatic jpw_pkg::t_in_item random_point();
        jpw_pkg::t_in_item it;
        int       k;
        int       px;
        int       py;
        longint   e;
        it.node      = ($urandom_range(9) < 6) ? jpw_pkg::NODE_W'($urandom_range(3))
                                               : jpw_pkg::NODE_W'($urandom);
        it.base_x    = rand_coord();
        it.base_y    = rand_coord();
        it.direction = 2'($urandom);
        k  = int'(it.node) % NUM_PTS;
        px = clamp32(longint'($signed(it.base_x)) + longint'(off_x[k]));
        py = clamp32(longint'($signed(it.base_y)) + longint'(off_y[k]));
        case ($urandom_range(9))
            0, 1, 2, 3: begin
                it.mouse_x = $urandom;
                it.mouse_y = $urandom;
            end
            4, 5, 6: begin
                // exactly on the radius or one LSB outside, along one axis
                case ($urandom_range(3))
                    0:       e = radius_q;
                    1:       e = -radius_q;
                    2:       e = radius_q + 1;
                    default: e = -radius_q - 1;
                endcase
                if ($urandom_range(1) == 0) begin
                    it.mouse_x = clamp32(longint'(px) + e);
                    it.mouse_y = py;
                end else begin
                    it.mouse_x = px;
                    it.mouse_y = clamp32(longint'(py) + e);
                end
            end
            default: begin
                it.mouse_x = clamp32(longint'(px) - radius_q / 2
                                     + longint'($urandom_range(32'(radius_q))) / 2);
                it.mouse_y = clamp32(longint'(py) - radius_q / 2
                                     + longint'($urandom_range(32'(radius_q))) / 2);
            end
        endcase
        return it;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("ERROR %0t ns %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        end
    endtask

    // Offer one transaction after a random gap; predict it once accepted
    task automatic send_point(input jpw_pkg::t_in_item it, input bit fixed,
                              input jpw_pkg::t_out_item want);
        jpw_pkg::t_out_item got;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        got = advance_point(it);
        awaited_positions.push_back(fixed ? want : got);
    endtask

    task automatic wait_drained();
        while (awaited_positions.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // APB write, then read back and compare
    task automatic write_reg(input logic [jpw_pkg::REG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        logic [31:0] stored;
        case (idx)
            jpw_pkg::REG_RADIUS:   stored = {1'b0, value[30:0]};
            jpw_pkg::REG_FRICTION: stored = {16'd0, value[15:0]};
            jpw_pkg::REG_STEP:     stored = {1'b0, value[30:0]};
            default:               stored = {27'd0, value[4:0]};
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        case (idx)
            jpw_pkg::REG_RADIUS:   radius_q   = longint'(stored);
            jpw_pkg::REG_FRICTION: friction_q = longint'(stored);
            jpw_pkg::REG_STEP:     step_q     = longint'(stored);
            default:               span_q     = longint'(stored);
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        if (prdata !== stored) begin
            report_mismatch($sformatf("register %0d read back", idx), 64'(prdata),
                            64'(stored));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result side: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_served != hold_asked) begin
            hold_served <= hold_asked;
            hold_left   <= HOLD_CYCLES;
            out_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin : check_result
        jpw_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (awaited_positions.size() == 0) begin
                report_mismatch("result with nothing outstanding", 64'(o_out_data), '0);
            end else begin
                want = awaited_positions.pop_front();
                if (o_out_data.node_out !== want.node_out) begin
                    report_mismatch("node_out", 64'(o_out_data.node_out),
                                    64'(want.node_out));
                end
                if (o_out_data.out_x !== want.out_x) begin
                    report_mismatch($sformatf("out_x of point %0d", want.node_out),
                                    64'(o_out_data.out_x), 64'(want.out_x));
                end
                if (o_out_data.out_y !== want.out_y) begin
                    report_mismatch($sformatf("out_y of point %0d", want.node_out),
                                    64'(o_out_data.out_y), 64'(want.out_y));
                end
                if (o_out_data.moved !== want.moved) begin
                    report_mismatch($sformatf("moved of point %0d", want.node_out),
                                    64'(o_out_data.moved), 64'(want.moved));
                end
            end
        end
    end

    // Watchdog: too long without any transaction on either channel
    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : run
        jpw_pkg::t_out_item none;
        logic [31:0]   cfg_radius;
        logic [31:0]   cfg_friction;
        logic [31:0]   cfg_step;
        logic [31:0]   cfg_span;
        none       = '0;
        radius_q   = longint'(jpw_pkg::RADIUS_RST);
        friction_q = longint'(jpw_pkg::FRICTION_RST);
        step_q     = longint'(jpw_pkg::STEP_RST);
        span_q     = longint'(jpw_pkg::SPAN_RST);
        for (int i = 0; i < NUM_PTS; i++) begin
            off_x[i] = 0;
            off_y[i] = 0;
            spd_x[i] = 0;
            spd_y[i] = 0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed vectors at reset settings (select radius 20.0)
        add_vector(0, 0, 0, 0, 0, jpw_pkg::DIR_POS_X, 1, 0, 0, 0);
        add_vector(63, P_MAX, P_MAX, P_MAX, P_MAX, jpw_pkg::DIR_NEG_Y, 1, P_MAX, P_MAX, 0);
        add_vector(1, P_MIN, P_MIN, P_MIN, P_MIN, jpw_pkg::DIR_NEG_X, 1, P_MIN, P_MIN, 0);
        // on the radius along each axis: no step
        add_vector(2, 0, 0, 32'h0014_0000, 0, jpw_pkg::DIR_POS_Y, 1, 0, 0, 0);
        add_vector(2, 0, 0, 0, -32'sh0014_0000, jpw_pkg::DIR_POS_Y, 1, 0, 0, 0);
        // one LSB outside the radius
        add_vector(3, 0, 0, 32'h0014_0001, 0, jpw_pkg::DIR_POS_X, 1, 0, 0, 1);
        // largest distance: the sum of squares overflows 64 bits
        add_vector(4, P_MAX, P_MAX, P_MIN, P_MIN, jpw_pkg::DIR_POS_X, 1, P_MAX, P_MAX, 1);
        add_vector(4, P_MIN, 0, P_MAX, 0, jpw_pkg::DIR_NEG_X, 0, 0, 0, 0);
        add_vector(4, 0, 0, 32'h0100_0000, 0, jpw_pkg::DIR_POS_Y, 0, 0, 0, 0);
        add_vector(4, 0, 0, 0, 32'h0100_0000, jpw_pkg::DIR_NEG_Y, 0, 0, 0, 0);
        // positive offset on top of the largest base: clamped display
        add_vector(5, P_MAX, P_MAX, P_MIN, P_MIN, jpw_pkg::DIR_POS_X, 1, P_MAX, P_MAX, 1);
        add_vector(5, P_MAX, P_MAX, P_MIN, P_MIN, jpw_pkg::DIR_POS_X, 1, P_MAX, P_MAX, 1);
        // negative offset under the smallest base: clamped the other way
        add_vector(6, P_MIN, P_MIN, P_MAX, P_MAX, jpw_pkg::DIR_NEG_X, 1, P_MIN, P_MIN, 1);
        add_vector(6, P_MIN, P_MIN, P_MAX, P_MAX, jpw_pkg::DIR_NEG_Y, 1, P_MIN, P_MIN, 1);
        add_vector(6, 32'h0001_0000, -32'sh0001_0000, P_MAX, P_MIN, jpw_pkg::DIR_POS_Y,
                   0, 0, 0, 0);
        add_vector(62, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
                   jpw_pkg::DIR_NEG_Y, 0, 0, 0, 0);
        add_vector(5, 0, 0, 32'h0014_0000, 0, jpw_pkg::DIR_NEG_X, 0, 0, 0, 0);
        add_vector(4, -32'sh0000_0100, 32'h0000_0100, 0, 0, jpw_pkg::DIR_POS_X, 0, 0, 0, 0);
        foreach (vectors[i]) begin
            send_point(vectors[i].stim, vectors[i].fixed, vectors[i].want);
        end
        in_valid <= 1'b0;
        wait_drained();

        // Random phases, each with its own settings and one of four idle patterns
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    cfg_radius   = 32'(jpw_pkg::RADIUS_RST);
                    cfg_friction = 32'(jpw_pkg::FRICTION_RST);
                    cfg_step     = 32'(jpw_pkg::STEP_RST);
                    cfg_span     = 32'(jpw_pkg::SPAN_RST);
                end
                1: begin
                    cfg_radius   = 32'h0000_0000;
                    cfg_friction = 32'h0000_FFFF;
                    cfg_step     = 32'h7FFF_FFFF;
                    cfg_span     = 32'd0;
                end
                2: begin
                    cfg_radius   = 32'h7FFF_FFFF;
                    cfg_friction = 32'h0000_0000;
                    cfg_step     = 32'h0000_0000;
                    cfg_span     = 32'd31;
                end
                3: begin
                    cfg_radius   = 32'h0000_8000;
                    cfg_friction = 32'h0000_FFFF;
                    cfg_step     = 32'h0001_0000;
                    cfg_span     = 32'd31;
                end
                default: begin
                    cfg_radius   = $urandom >> $urandom_range(24);
                    cfg_friction = $urandom;
                    cfg_step     = $urandom >> $urandom_range(24);
                    cfg_span     = $urandom;
                end
            endcase
            write_reg(jpw_pkg::REG_RADIUS, cfg_radius);
            write_reg(jpw_pkg::REG_FRICTION, cfg_friction);
            write_reg(jpw_pkg::REG_STEP, cfg_step);
            write_reg(jpw_pkg::REG_SPAN, cfg_span);
            case (p % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 71;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 71;
                end
                default: begin
                    send_idle_pct = 6;
                    stall_pct     = 6;
                end
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                // long result hold-off while the sender keeps offering
                if (p == 0 && i == 60) begin
                    hold_asked <= hold_asked + 1;
                end
                // sender pauses until everything outstanding has come back
                if (p == 1 && i == 100) begin
                    in_valid <= 1'b0;
                    wait_drained();
                end
                send_point(random_point(), 1'b0, none);
            end
            in_valid <= 1'b0;
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
